// ===== rtl/core/lidar_ray_ground_classifier_defines.svh =====
// assertion macros for the lidar ray ground classifier
`ifndef LIDAR_RAY_GROUND_CLASSIFIER_DEFINES_SVH
`define LIDAR_RAY_GROUND_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define LRGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrgc assertion failed");

// next-cycle implication, disabled during reset
`define LRGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrgc assertion failed");

`else

`define LRGC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LRGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/lrgc_pkg.sv =====
// types, constants and helpers shared by the lidar ray ground classifier
package lrgc_pkg;

  localparam int PIDX_W   = 20;
  localparam int RADIUS_W = 18;
  localparam int HEIGHT_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // widths of the band arithmetic
  localparam int BAND_W  = 36;
  localparam int CMP_W   = 38;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_HEIGHT = 3'd0,
    REG_LOCAL_SLOPE   = 3'd1,
    REG_GENERAL_SLOPE = 3'd2,
    REG_MIN_BAND      = 3'd3,
    REG_CLOSE_GAP     = 3'd4,
    REG_RECLASS_GAP   = 3'd5,
    REG_CLIP_HEIGHT   = 3'd6,
    REG_MIN_DISTANCE  = 3'd7
  } lrgc_reg_t;

  // point classes
  typedef enum logic [1:0] {
    CLS_REMOVED    = 2'd0,
    CLS_GROUND     = 2'd1,
    CLS_NOT_GROUND = 2'd2
  } lrgc_class_t;

  typedef struct packed {
    logic                       ray_start;
    logic [RADIUS_W-1:0]        radius_mm;
    logic signed [HEIGHT_W-1:0] height_mm;
    logic [PIDX_W-1:0]          point_index;
  } lrgc_in_t;

  typedef struct packed {
    logic [PIDX_W-1:0] point_index_out;
    lrgc_class_t       point_class;
  } lrgc_out_t;

  typedef struct packed {
    logic [12:0]        sensor_height_mm;
    logic [15:0]        local_slope_tan_q16;
    logic [15:0]        general_slope_tan_q16;
    logic [9:0]         min_band_mm;
    logic [9:0]         close_gap_mm;
    logic [12:0]        reclass_gap_mm;
    logic signed [15:0] clip_height_mm;
    logic [15:0]        min_distance_mm;
  } lrgc_cfg_t;

  // state carried along one ray
  typedef struct packed {
    logic [RADIUS_W-1:0]        last_radius;
    logic signed [HEIGHT_W-1:0] last_height;
    logic                       last_ground;
  } lrgc_ray_t;

  // register reset values
  localparam logic [12:0]        SENSOR_HEIGHT_RST = 13'd1780;
  localparam logic [15:0]        LOCAL_SLOPE_RST   = 16'd9210;
  localparam logic [15:0]        GENERAL_SLOPE_RST = 16'd5734;
  localparam logic [9:0]         MIN_BAND_RST      = 10'd50;
  localparam logic [9:0]         CLOSE_GAP_RST     = 10'd10;
  localparam logic [12:0]        RECLASS_GAP_RST   = 13'd200;
  localparam logic signed [15:0] CLIP_HEIGHT_RST   = 16'sd200;
  localparam logic [15:0]        MIN_DISTANCE_RST  = 16'd2400;
  localparam logic signed [HEIGHT_W-1:0] LAST_HEIGHT_RST = -16'sd1780;

  // true when -band <= diff * 65536 <= band
  function automatic logic in_band(input logic signed [16:0] diff,
                                   input logic signed [BAND_W-1:0] band);
    logic signed [CMP_W-1:0] d_x;
    logic signed [CMP_W-1:0] b_x;
    d_x = {{(CMP_W-33){diff[16]}}, diff, 16'b0};
    b_x = {{(CMP_W-BAND_W){band[BAND_W-1]}}, band};
    return (d_x <= b_x) && (d_x >= -b_x);
  endfunction

endpackage

// ===== rtl/core/lidar_ray_ground_classifier.sv =====
// Lidar ray ground classifier: one point in per clock unless stalled, one class
// out per point. Points enter in radius order along a ray, ray_start marking each
// new ray. The block takes a point every clock while in_stall is low; the point
// passes the input register, then the result register presents its class. The
// rate is set by the ray state loop: the previous kept point's radius, height and
// ground mark are read, run through the gap multiply and band compares, and
// written back in the same clock. Configuration writes are always ready and must
// only happen while no point is in flight. point_index_out carries the low
// min(INDEX_WIDTH, PIDX_W) bits of the point index.
module lidar_ray_ground_classifier #(
  parameter int INDEX_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lrgc_pkg::lrgc_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lrgc_pkg::lrgc_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrgc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrgc_pkg::*;

  `include "lidar_ray_ground_classifier_defines.svh"

  localparam int KEEP_W = (INDEX_WIDTH < PIDX_W) ? INDEX_WIDTH : PIDX_W;

  lrgc_cfg_t         cfg_r;
  lrgc_ray_t         ray_r;
  lrgc_ray_t         ray_nxt;
  lrgc_class_t       cls;
  logic              s1_valid_r;
  lrgc_in_t          s1_item_r;
  logic              out_valid_r;
  logic [KEEP_W-1:0] out_idx_r;
  lrgc_class_t       out_cls_r;
  logic              s2_free;
  logic              adv;
  logic              in_fire;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_height_mm      <= SENSOR_HEIGHT_RST;
      cfg_r.local_slope_tan_q16   <= LOCAL_SLOPE_RST;
      cfg_r.general_slope_tan_q16 <= GENERAL_SLOPE_RST;
      cfg_r.min_band_mm           <= MIN_BAND_RST;
      cfg_r.close_gap_mm          <= CLOSE_GAP_RST;
      cfg_r.reclass_gap_mm        <= RECLASS_GAP_RST;
      cfg_r.clip_height_mm        <= CLIP_HEIGHT_RST;
      cfg_r.min_distance_mm       <= MIN_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lrgc_reg_t'(cfg_index))
        REG_SENSOR_HEIGHT: cfg_r.sensor_height_mm      <= cfg_data[12:0];
        REG_LOCAL_SLOPE:   cfg_r.local_slope_tan_q16   <= cfg_data;
        REG_GENERAL_SLOPE: cfg_r.general_slope_tan_q16 <= cfg_data;
        REG_MIN_BAND:      cfg_r.min_band_mm           <= cfg_data[9:0];
        REG_CLOSE_GAP:     cfg_r.close_gap_mm          <= cfg_data[9:0];
        REG_RECLASS_GAP:   cfg_r.reclass_gap_mm        <= cfg_data[12:0];
        REG_CLIP_HEIGHT:   cfg_r.clip_height_mm        <= $signed(cfg_data);
        REG_MIN_DISTANCE:  cfg_r.min_distance_mm       <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake between input register and result register
  assign s2_free  = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_fire  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire || (s1_valid_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  // classification datapath
  lrgc_judge u_judge (
    .cfg         (cfg_r),
    .ray         (ray_r),
    .item        (s1_item_r),
    .point_class (cls),
    .ray_nxt     (ray_nxt)
  );

  // ray state, updated as each point leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.last_radius <= '0;
      ray_r.last_height <= LAST_HEIGHT_RST;
      ray_r.last_ground <= 1'b0;
    end else if (adv) begin
      ray_r <= ray_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r <= s1_item_r.point_index[KEEP_W-1:0];
      out_cls_r <= cls;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.point_index_out = PIDX_W'(out_idx_r);
  assign out_data.point_class     = out_cls_r;

  // checks on the pipeline and ray state
  `LRGC_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r)
  `LRGC_ASSERT_NEXT(a_removed_keeps_state, clk, rst_n, adv && !s1_item_r.ray_start && cls == CLS_REMOVED, $stable(ray_r))
  `LRGC_ASSERT_NEXT(a_kept_updates_radius, clk, rst_n, adv && cls != CLS_REMOVED, ray_r.last_radius == $past(s1_item_r.radius_mm))
  `LRGC_ASSERT_NEXT(a_ground_mark_matches, clk, rst_n, adv && cls != CLS_REMOVED, ray_r.last_ground == (out_cls_r == CLS_GROUND))

endmodule

// ===== rtl/core/lrgc_judge.sv =====
// classification datapath: removal test, slope bands and next ray state
module lrgc_judge (
  input  lrgc_pkg::lrgc_cfg_t   cfg,
  input  lrgc_pkg::lrgc_ray_t   ray,
  input  lrgc_pkg::lrgc_in_t    item,
  output lrgc_pkg::lrgc_class_t point_class,
  output lrgc_pkg::lrgc_ray_t   ray_nxt
);
  import lrgc_pkg::*;

  lrgc_ray_t               ray_eff;
  logic                    removed;
  logic signed [18:0]      gap;
  logic signed [BAND_W-1:0] band_raw;
  logic signed [BAND_W-1:0] band_sel;
  logic signed [BAND_W-1:0] min_band_q16;
  logic [33:0]             gen_band_u;
  logic signed [BAND_W-1:0] gen_band;
  logic signed [16:0]      diff;
  logic signed [16:0]      to_ground;
  logic                    gap_over_close;
  logic                    gap_over_reclass;
  logic                    ground;

  // a new ray starts from a cleared state
  always_comb begin
    if (item.ray_start) begin
      ray_eff.last_radius = '0;
      ray_eff.last_height = -$signed({3'b0, cfg.sensor_height_mm});
      ray_eff.last_ground = 1'b0;
    end else begin
      ray_eff = ray;
    end
  end

  // clip height and minimum distance
  assign removed = (item.height_mm > cfg.clip_height_mm) ||
                   (item.radius_mm < {2'b0, cfg.min_distance_mm});

  // local band from the radial gap, floored for non-close gaps
  assign gap = $signed({1'b0, item.radius_mm}) - $signed({1'b0, ray_eff.last_radius});
  assign band_raw = $signed({1'b0, cfg.local_slope_tan_q16}) * gap;
  assign min_band_q16 = $signed({10'b0, cfg.min_band_mm, 16'b0});
  assign gap_over_close   = gap > $signed({9'b0, cfg.close_gap_mm});
  assign gap_over_reclass = gap > $signed({6'b0, cfg.reclass_gap_mm});
  assign band_sel = (gap_over_close && (band_raw < min_band_q16)) ? min_band_q16 : band_raw;

  // general band grows with radius
  assign gen_band_u = cfg.general_slope_tan_q16 * item.radius_mm;
  assign gen_band   = $signed({2'b0, gen_band_u});

  // height steps against previous point and against the ground plane
  assign diff      = $signed({item.height_mm[HEIGHT_W-1], item.height_mm}) -
                     $signed({ray_eff.last_height[HEIGHT_W-1], ray_eff.last_height});
  assign to_ground = $signed({item.height_mm[HEIGHT_W-1], item.height_mm}) +
                     $signed({4'b0, cfg.sensor_height_mm});

  // ground decision
  always_comb begin
    if (in_band(diff, band_sel)) begin
      ground = ray_eff.last_ground || in_band(to_ground, gen_band);
    end else begin
      ground = gap_over_reclass && in_band(to_ground, band_sel);
    end
  end

  // class and state to carry forward
  always_comb begin
    if (removed) begin
      point_class = CLS_REMOVED;
      ray_nxt     = ray_eff;
    end else begin
      point_class         = ground ? CLS_GROUND : CLS_NOT_GROUND;
      ray_nxt.last_radius = item.radius_mm;
      ray_nxt.last_height = item.height_mm;
      ray_nxt.last_ground = ground;
    end
  end

endmodule
